FILE: hdl/i2rd_pkg.sv
`timescale 1ns / 1ps

package i2rd_pkg;

  localparam int TwosBitsDefault = 16;
  localparam int MaxRun          = 31;

  localparam logic [2:0] OpBin  = 3'd0;
  localparam logic [2:0] OpOct  = 3'd1;
  localparam logic [2:0] OpHex  = 3'd2;
  localparam logic [2:0] OpBcd  = 3'd3;
  localparam logic [2:0] OpTwos = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [6:0] ascii_char;
    logic       is_last;
    logic       no_digits;
  } out_t;

  typedef struct packed {
    logic load;
    logic dab;
    logic shift;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic in_bcd;
    logic in_twos;
    logic dab_done;
    logic top_zero;
    logic last;
  } stat_t;

  function automatic logic [6:0] ascii_of(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + {3'b000, d};
    end else begin
      c = 7'h41 + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

FILE: hdl/i2rd_ctrl.sv
`timescale 1ns / 1ps

module i2rd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  i2rd_pkg::stat_t stat,
  output i2rd_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    DAB,
    SKIP,
    EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          if (stat.in_empty) begin
            cmd.emit_empty = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (stat.in_bcd) begin
              state_nxt = DAB;
            end else if (stat.in_twos) begin
              state_nxt = EMIT;
            end else begin
              state_nxt = SKIP;
            end
          end
        end
      end
      DAB: begin
        cmd.dab = 1'b1;
        if (stat.dab_done) begin
          state_nxt = SKIP;
        end
      end
      SKIP: begin
        // drop leading zero digits; a positive value always has a nonzero one
        if (stat.top_zero) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = EMIT;
        end
      end
      EMIT: begin
        cmd.emit  = 1'b1;
        cmd.shift = 1'b1;
        if (stat.last) begin
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != IDLE);

endmodule

FILE: hdl/i2rd_dp.sv
`timescale 1ns / 1ps

module i2rd_dp #(
  parameter int TWOS_BITS = i2rd_pkg::TwosBitsDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  i2rd_pkg::in_t   in_data,
  input  i2rd_pkg::cmd_t  cmd,
  output i2rd_pkg::stat_t stat,
  output logic            out_valid,
  output i2rd_pkg::out_t  out_data
);

  localparam int TwoN = (TWOS_BITS > i2rd_pkg::MaxRun) ? i2rd_pkg::MaxRun :
                        (TWOS_BITS < 1) ? 1 : TWOS_BITS;
  localparam int TwoSh = 32 - TwoN;

  logic [39:0]    sreg_r, sreg_nxt;
  logic [31:0]    bin_r, bin_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [4:0]     dcnt_r, dcnt_nxt;
  logic [2:0]     mode_r, mode_nxt;
  logic           out_valid_r;
  i2rd_pkg::out_t out_r, out_nxt;
  logic [3:0]     top;
  logic [39:0]    adj;
  logic [2:0]     op_in;
  logic [31:0]    v_in;

  assign op_in = in_data.operation;
  assign v_in  = in_data.value;

  always_comb begin
    case (mode_r)
      i2rd_pkg::OpBin, i2rd_pkg::OpTwos: top = {3'b000, sreg_r[39]};
      i2rd_pkg::OpOct:                   top = {1'b0, sreg_r[39:37]};
      default:                           top = sreg_r[39:36];
    endcase
  end

  always_comb begin
    stat.in_empty = (op_in > i2rd_pkg::OpTwos) ||
                    ((op_in != i2rd_pkg::OpTwos) && ((v_in == '0) || v_in[31]));
    stat.in_bcd   = (op_in == i2rd_pkg::OpBcd);
    stat.in_twos  = (op_in == i2rd_pkg::OpTwos);
    stat.dab_done = (dcnt_r == 5'd31);
    stat.top_zero = (top == 4'd0);
    stat.last     = (cnt_r == 6'd1);
  end

  // add 3 to each BCD nibble of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      adj[4*i +: 4] = (sreg_r[4*i +: 4] >= 4'd5) ? sreg_r[4*i +: 4] + 4'd3 :
                                                    sreg_r[4*i +: 4];
    end
  end

  always_comb begin
    sreg_nxt = sreg_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    dcnt_nxt = dcnt_r;
    mode_nxt = mode_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      mode_nxt = op_in;
      dcnt_nxt = '0;
      bin_nxt  = v_in;
      case (op_in)
        i2rd_pkg::OpBin: begin
          sreg_nxt = {v_in, 8'h00};
          cnt_nxt  = 6'd32;
        end
        i2rd_pkg::OpOct: begin
          sreg_nxt = {1'b0, v_in, 7'h00};
          cnt_nxt  = 6'd11;
        end
        i2rd_pkg::OpHex: begin
          sreg_nxt = {v_in, 8'h00};
          cnt_nxt  = 6'd8;
        end
        i2rd_pkg::OpBcd: begin
          sreg_nxt = '0;
          cnt_nxt  = 6'd10;
        end
        default: begin
          sreg_nxt = {v_in, 8'h00} << TwoSh;
          cnt_nxt  = 6'(TwoN);
        end
      endcase
    end else if (cmd.dab) begin
      {sreg_nxt, bin_nxt} = {adj[38:0], bin_r, 1'b0};
      dcnt_nxt = dcnt_r + 5'd1;
    end else if (cmd.shift) begin
      case (mode_r)
        i2rd_pkg::OpBin, i2rd_pkg::OpTwos: sreg_nxt = sreg_r << 1;
        i2rd_pkg::OpOct:                   sreg_nxt = sreg_r << 3;
        default:                           sreg_nxt = sreg_r << 4;
      endcase
      cnt_nxt = cnt_r - 6'd1;
    end
    if (cmd.emit) begin
      out_nxt.digit      = top;
      out_nxt.ascii_char = i2rd_pkg::ascii_of(top);
      out_nxt.is_last    = (cnt_r == 6'd1);
      out_nxt.no_digits  = 1'b0;
    end else if (cmd.emit_empty) begin
      out_nxt.digit      = 4'd0;
      out_nxt.ascii_char = 7'd0;
      out_nxt.is_last    = 1'b1;
      out_nxt.no_digits  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | cmd.emit_empty;
    end
    sreg_r <= sreg_nxt;
    bin_r  <= bin_nxt;
    cnt_r  <= cnt_nxt;
    dcnt_r <= dcnt_nxt;
    mode_r <= mode_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/integer_to_radix_digits_top.sv
`timescale 1ns / 1ps

// Converts a signed 32-bit value into digits, most significant first, one
// beat per cycle on out_valid; the receiver cannot stall, so out_data must be
// taken whenever out_valid is high. An item is taken when start is high and
// busy is low. Empty runs (value not positive in binary, octal, hex or BCD
// mode, or an unused operation code) give one beat in the next cycle with
// no_digits set and keep busy low. Binary, octal and hex walk the value one
// digit position per cycle, first dropping leading zeros and then emitting,
// with a step from dropping to emitting in between. BCD first runs a
// shift-and-add-3 conversion, then walks 10 positions the same way. Two's
// complement mode emits the low TWOS_BITS bits (clamped to 1..31) at once.
// The last beat shows in the same cycle in which busy falls.
module integer_to_radix_digits_top #(
  parameter int TWOS_BITS = i2rd_pkg::TwosBitsDefault
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  i2rd_pkg::in_t  in_data,
  output logic           out_valid,
  output i2rd_pkg::out_t out_data
);

  i2rd_pkg::cmd_t  cmd;
  i2rd_pkg::stat_t stat;

  i2rd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  i2rd_dp #(
    .TWOS_BITS (TWOS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int         TwosBits     = i2rd_pkg::TwosBitsDefault;
  localparam logic [2:0] OpUnusedLo   = 3'd5;
  localparam logic [2:0] OpUnusedMid  = 3'd6;
  localparam logic [2:0] OpUnusedHi   = 3'd7;
  localparam logic [6:0] AsciiZero    = 7'h30;
  localparam logic [6:0] AsciiA       = 7'h41;
  localparam int         CycleLimit   = 200000;
  localparam int         RandomItems  = 395;
  localparam int         DrainCycles  = 60;
  localparam int         NumRows      = 25;
  localparam i2rd_pkg::out_t EmptyBeat = {4'd0, 7'd0, 1'b1, 1'b1};
  localparam i2rd_pkg::out_t NoBeat    = {4'd0, 7'd0, 1'b0, 1'b0};

  typedef struct {
    logic [2:0]     op;
    logic [31:0]    value;
    bit             typed;
    i2rd_pkg::out_t want;
  } row_t;

  // Typed-in rows give their single beat; the rest go through the predictor.
  row_t rows [NumRows] = '{
    '{i2rd_pkg::OpBin,  32'd1,          1'b1, {4'd1,  7'h31, 1'b1, 1'b0}},
    '{i2rd_pkg::OpBin,  32'd0,          1'b1, EmptyBeat},
    '{i2rd_pkg::OpBin,  32'hFFFF_FFFF,  1'b1, EmptyBeat},
    '{i2rd_pkg::OpBin,  32'h8000_0000,  1'b1, EmptyBeat},
    '{i2rd_pkg::OpBin,  32'h7FFF_FFFF,  1'b0, NoBeat},
    '{i2rd_pkg::OpBin,  32'd2,          1'b0, NoBeat},
    '{i2rd_pkg::OpOct,  32'd7,          1'b1, {4'd7,  7'h37, 1'b1, 1'b0}},
    '{i2rd_pkg::OpOct,  32'h7FFF_FFFF,  1'b0, NoBeat},
    '{i2rd_pkg::OpOct,  32'd0,          1'b1, EmptyBeat},
    '{i2rd_pkg::OpHex,  32'd15,         1'b1, {4'd15, 7'h46, 1'b1, 1'b0}},
    '{i2rd_pkg::OpHex,  32'h7FFF_FFFF,  1'b0, NoBeat},
    '{i2rd_pkg::OpHex,  32'h0000_0010,  1'b0, NoBeat},
    '{i2rd_pkg::OpHex,  32'hFFFF_FFFB,  1'b1, EmptyBeat},
    '{i2rd_pkg::OpBcd,  32'd9,          1'b1, {4'd9,  7'h39, 1'b1, 1'b0}},
    '{i2rd_pkg::OpBcd,  32'd2147483647, 1'b0, NoBeat},
    '{i2rd_pkg::OpBcd,  32'd1000000000, 1'b0, NoBeat},
    '{i2rd_pkg::OpBcd,  32'd0,          1'b1, EmptyBeat},
    '{i2rd_pkg::OpTwos, 32'd0,          1'b0, NoBeat},
    '{i2rd_pkg::OpTwos, 32'hFFFF_FFFF,  1'b0, NoBeat},
    '{i2rd_pkg::OpTwos, 32'h8000_0000,  1'b0, NoBeat},
    '{i2rd_pkg::OpTwos, 32'h0000_8000,  1'b0, NoBeat},
    '{i2rd_pkg::OpTwos, 32'h0000_7FFF,  1'b0, NoBeat},
    '{OpUnusedLo,       32'd123,        1'b1, EmptyBeat},
    '{OpUnusedMid,      32'd0,          1'b1, EmptyBeat},
    '{OpUnusedHi,       32'hFFFF_FFFF,  1'b1, EmptyBeat}
  };

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  i2rd_pkg::in_t  in_data = '0;
  logic           out_valid;
  i2rd_pkg::out_t out_data;

  // Sideband that travels with in_data: a typed-in beat for directed rows.
  bit             row_typed = 1'b0;
  i2rd_pkg::out_t row_want = NoBeat;

  i2rd_pkg::out_t pending_digits [$];
  i2rd_pkg::out_t oldest_digit;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             burst_left = 0;

  integer_to_radix_digits_top #(.TWOS_BITS(TwosBits)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic i2rd_pkg::out_t digit_beat(input logic [3:0] d, input bit last);
    i2rd_pkg::out_t b;
    b.digit      = d;
    b.ascii_char = (d < 4'd10) ? AsciiZero + {3'b000, d} : AsciiA + {3'b000, d} - 7'd10;
    b.is_last    = last;
    b.no_digits  = 1'b0;
    return b;
  endfunction

  function automatic void expand_digits(input i2rd_pkg::in_t item);
    logic [31:0] v;
    logic [3:0]  digs [32];
    int          radix;
    int          n;
    int          nbits;
    v = item.value;
    n = 0;
    if (item.operation == i2rd_pkg::OpTwos) begin
      nbits = (TwosBits < 1) ? 1 :
              (TwosBits > i2rd_pkg::MaxRun) ? i2rd_pkg::MaxRun : TwosBits;
      for (int i = 0; i < nbits; i++)
        pending_digits.push_back(digit_beat({3'b000, v[nbits-1-i]}, i + 1 == nbits));
    end else if (item.operation > i2rd_pkg::OpTwos || v == 32'd0 || v[31]) begin
      pending_digits.push_back(EmptyBeat);
    end else begin
      case (item.operation)
        i2rd_pkg::OpBin: radix = 2;
        i2rd_pkg::OpOct: radix = 8;
        i2rd_pkg::OpHex: radix = 16;
        default:         radix = 10;
      endcase
      while (v > 0 && n < i2rd_pkg::MaxRun) begin
        digs[n] = 4'(v % radix);
        v = v / radix;
        n++;
      end
      for (int k = 0; k < n; k++)
        pending_digits.push_back(digit_beat(digs[n-1-k], k + 1 == n));
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        if (row_typed) pending_digits.push_back(row_want);
        else expand_digits(in_data);
      end
      if (out_valid) begin
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %p", $time, out_data);
          mismatch_count++;
        end else begin
          oldest_digit = pending_digits.pop_front();
          check_field("digit", 32'(oldest_digit.digit), 32'(out_data.digit));
          check_field("ascii_char", 32'(oldest_digit.ascii_char),
                      32'(out_data.ascii_char));
          check_field("is_last", 32'(oldest_digit.is_last), 32'(out_data.is_last));
          check_field("no_digits", 32'(oldest_digit.no_digits),
                      32'(out_data.no_digits));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Hold start and the item until the block takes them; return once busy is low.
  task automatic send_item(input i2rd_pkg::in_t item, input bit typed,
                           input i2rd_pkg::out_t want);
    start     <= 1'b1;
    in_data   <= item;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Close a burst with a random gap; some bursts run long with no gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 12);
    end
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom & 32'h7FFF_FFFF;
      2: v = $urandom_range(0, 20);
      3: v = ($urandom_range(0, 1) == 1) ? (32'd1 << k) : (32'd1 << k) - 32'd1;
      4: v = -$urandom_range(0, 5);
      default: v = $urandom & 32'h0000_FFFF;
    endcase
    return v;
  endfunction

  initial begin
    i2rd_pkg::in_t item;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NumRows; r++) begin
      item.operation = rows[r].op;
      item.value     = rows[r].value;
      send_item(item, rows[r].typed, rows[r].want);
      pace_sender();
    end

    for (int n = 0; n < RandomItems; n++) begin
      if ($urandom_range(0, 19) < 18)
        item.operation = 3'($urandom_range(i2rd_pkg::OpBin, i2rd_pkg::OpTwos));
      else item.operation = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
      item.value = pick_value();
      send_item(item, 1'b0, NoBeat);
      pace_sender();
    end
    start <= 1'b0;

    // Drain, then watch for stray beats.
    do @(posedge clk); while (pending_digits.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/i2rd_pkg.sv
hdl/i2rd_ctrl.sv
hdl/i2rd_dp.sv
hdl/integer_to_radix_digits_top.sv
tb/tb.sv
